/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros: assertion shorthands shared by the trainer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
  `ASSERT_AT(lbl, clk_s, rst_s, !(cond), msg)

`endif

/* hw/rtl/mbt_pkg.sv */
// ----------------------------------------------------------------------------
// mbt_pkg: shared types, codes and arithmetic helpers of the trainer
// Q8.16 helpers, tanh table, cell record and sequencer codes.
// ----------------------------------------------------------------------------
package mbt_pkg;

  localparam int HIDDEN_UNITS_DEF = 8;
  localparam int Q_W      = 24;
  localparam int OPA_W    = 40;
  localparam int OPB_W    = 24;
  localparam int ACC_W    = 64;
  localparam int RQ_W     = 48;
  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 48;

  localparam logic [1:0] MODE_TRAIN = 2'd1;
  localparam logic [1:0] MODE_LOAD  = 2'd2;

  typedef enum logic [2:0] {
    REG_BIAS_LEVEL    = 3'd0,
    REG_RATE_HIDDEN   = 3'd1,
    REG_RATE_OUTPUT   = 3'd2,
    REG_WEIGHT_LIMIT  = 3'd3,
    REG_HIDDEN_IN_USE = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOADW, ST_FETCH, ST_ISSUE, ST_WAIT,
    ST_POST, ST_SHIFT, ST_PRED, ST_ERR, ST_DONE
  } state_t;

  typedef enum logic [1:0] {PASS_FWD, PASS_RATE, PASS_OUT, PASS_HID} pass_t;

  typedef enum logic [1:0] {FIELD_W0, FIELD_W1, FIELD_W2, FIELD_WO} field_t;

  // weights of one hidden unit plus its last activation
  typedef struct packed {
    logic signed [Q_W-1:0] w0;
    logic signed [Q_W-1:0] w1;
    logic signed [Q_W-1:0] w2;
    logic signed [Q_W-1:0] wo;
    logic signed [17:0]    h;
  } cell_t;

  typedef struct packed {
    field_t                field;
    logic signed [Q_W-1:0] value;
  } cell_wr_t;

  // round a Q32.32 product to Q32.16 (add half, floor)
  function automatic logic signed [RQ_W-1:0] rnd16(input logic signed [ACC_W-1:0] v);
    return RQ_W'((v + 64'sd32768) >>> 16);
  endfunction

  function automatic logic signed [Q_W-1:0] sat24(input logic signed [48:0] v);
    if (v > 49'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -49'sd8388608) begin
      return 24'sh800000;
    end
    return v[Q_W-1:0];
  endfunction

  // weight minus a rounded change, kept wide
  function automatic logic signed [48:0] sub_w(input logic signed [Q_W-1:0] w,
                                               input logic signed [RQ_W-1:0] r);
    return 49'(w) - 49'(r);
  endfunction

  function automatic logic [16:0] tanh_tab(input logic [4:0] k);
    case (k)
      5'd0:  return 17'd0;
      5'd1:  return 17'd16051;
      5'd2:  return 17'd30286;
      5'd3:  return 17'd41625;
      5'd4:  return 17'd49912;
      5'd5:  return 17'd55593;
      5'd6:  return 17'd59320;
      5'd7:  return 17'd61694;
      5'd8:  return 17'd63179;
      5'd9:  return 17'd64096;
      5'd10: return 17'd64659;
      5'd11: return 17'd65003;
      5'd12: return 17'd65212;
      5'd13: return 17'd65339;
      5'd14: return 17'd65417;
      5'd15: return 17'd65464;
      default: return 17'd65492;
    endcase
  endfunction

  // tanh by table and floored interpolation on the magnitude
  function automatic logic signed [17:0] tanh_q(input logic signed [RQ_W-1:0] x);
    logic [RQ_W-1:0] m;
    logic [3:0]      k;
    logic [16:0]     y0;
    logic [16:0]     y1;
    logic [30:0]     pr;
    logic [16:0]     y;
    m  = x[RQ_W-1] ? RQ_W'(-x) : RQ_W'(x);
    k  = m[17:14];
    y0 = tanh_tab({1'b0, k});
    y1 = tanh_tab({1'b0, k} + 5'd1);
    pr = 31'(y1 - y0) * 31'(m[13:0]);
    y  = y0 + 17'(pr >> 14);
    if (m >= 48'd262144) begin
      y = 17'd65492;
    end
    return x[RQ_W-1] ? -$signed({1'b0, y}) : $signed({1'b0, y});
  endfunction

endpackage

/* hw/rtl/mbt_cell.sv */
// ----------------------------------------------------------------------------
// mbt_cell: one hidden unit's storage in the weight ring
// Holds three input weights, the output weight and the activation, and
// hands them to its neighbor on every ring shift.
// ----------------------------------------------------------------------------
module mbt_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  mbt_pkg::cell_t   d,
  input  logic             wr_en,
  input  mbt_pkg::cell_wr_t wr,
  output mbt_pkg::cell_t   q
);
  import mbt_pkg::*;

  // direct load has priority, otherwise take the neighbor on shift
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (wr_en) begin
      unique case (wr.field)
        FIELD_W0: q.w0 <= wr.value;
        FIELD_W1: q.w1 <= wr.value;
        FIELD_W2: q.w2 <= wr.value;
        FIELD_WO: q.wo <= wr.value;
        default:  q.wo <= q.wo;
      endcase
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

/* hw/rtl/mbt_mac.sv */
// ----------------------------------------------------------------------------
// mbt_mac: shared multiply-accumulate unit
// 40x24 signed product in two 21x24 halves, exact 64-bit accumulate and a
// rounded Q32.16 copy of the sum.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbt_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               clr,
  input  logic signed [mbt_pkg::OPA_W-1:0]   a,
  input  logic signed [mbt_pkg::OPB_W-1:0]   b,
  output logic signed [mbt_pkg::ACC_W-1:0]   acc,
  output logic signed [mbt_pkg::RQ_W-1:0]    rq,
  output logic                               busy,
  output logic                               done
);
  import mbt_pkg::*;

  typedef enum logic [2:0] {PH_IDLE, PH_LO, PH_HI, PH_TOP, PH_RND} mac_phase_t;

  mac_phase_t              phase;
  logic signed [OPA_W-1:0] a_r;
  logic signed [OPB_W-1:0] b_r;
  logic                    clr_r;
  logic signed [20:0]      mul_a;
  logic signed [44:0]      prod;
  logic signed [44:0]      p;

  // low half unsigned, high half signed
  always_comb begin
    mul_a = (phase == PH_LO) ? $signed({1'b0, a_r[19:0]}) : $signed({a_r[39], a_r[39:20]});
  end
  assign prod = mul_a * b_r;
  assign busy = (phase != PH_IDLE);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        PH_IDLE: if (start) phase <= PH_LO;
        PH_LO:   phase <= PH_HI;
        PH_HI:   phase <= PH_TOP;
        PH_TOP:  phase <= PH_RND;
        PH_RND: begin
          phase <= PH_IDLE;
          done  <= 1'b1;
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (phase)
      PH_IDLE: begin
        if (start) begin
          a_r   <= a;
          b_r   <= b;
          clr_r <= clr;
        end
      end
      PH_LO: p <= prod;
      PH_HI: begin
        acc <= (clr_r ? '0 : acc) + ACC_W'(p);
        p   <= prod;
      end
      PH_TOP: acc <= acc + (ACC_W'(p) <<< 20);
      PH_RND: rq <= rnd16(acc);
      default: p <= p;
    endcase
  end

  `ASSERT_NEVER(a_mac_start_busy, clk, rst, start && busy, "mac started while busy")

endmodule

/* hw/rtl/mlp_backprop_trainer.sv */
// ----------------------------------------------------------------------------
// mlp_backprop_trainer: two-input tanh perceptron with online backprop
// Weights live in a ring of cells, one per hidden unit; the ring rotates
// each unit past one shared multiply-accumulate unit.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tuser mode, tdata inputs and load data
//   m_*      out  m_tvalid/m_tready  tdata prediction and error
//   cfg_*    in   cfg_we             cfg_index, cfg_data
//
// Each multiply step runs on the shared mac unit. Predict runs a forward
// pass over every unit and only shifts the idle ones; training adds a
// rate step, an output pass and a hidden pass. A load writes at most one weight.
// Reset clears the weights at once; no sweep is needed.
// One item at a time; s_tready is high while idle, even while a result waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlp_backprop_trainer #(
  parameter int HIDDEN_UNITS = mbt_pkg::HIDDEN_UNITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // in_a, in_b, target, weight_index, weight_value, zero pad
  input  logic [mbt_pkg::S_TDATA_W-1:0]    s_tdata,
  // mode
  input  logic [1:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // prediction, error
  output logic [mbt_pkg::M_TDATA_W-1:0]    m_tdata,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_index,
  input  logic [23:0]                      cfg_data
);
  import mbt_pkg::*;

  localparam int UW = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int CW = $clog2(HIDDEN_UNITS + 1);

  // configuration
  logic signed [Q_W-1:0] bias_level;
  logic [22:0]           rate_hidden;
  logic [22:0]           rate_output;
  logic [22:0]           weight_limit;
  logic [3:0]            hidden_in_use;

  // captured item
  logic [1:0]            mode_r;
  logic signed [Q_W-1:0] x_a;
  logic signed [Q_W-1:0] x_b;
  logic signed [Q_W-1:0] tgt;
  logic [4:0]            widx;
  logic signed [Q_W-1:0] wval;

  // sequencer
  state_t                state;
  state_t                state_next;
  pass_t                 pass;
  logic [2:0]            op;
  logic [2:0]            last_op;
  logic [UW-1:0]         ucnt;
  logic [CW-1:0]         n_act;
  logic                  active;
  logic                  ucnt_last;
  logic                  accept;
  logic                  mac_start;
  logic                  ring_shift;
  logic                  load_we;
  logic                  out_load;

  // datapath
  cell_t                 work;
  cell_t                 ring [HIDDEN_UNITS];
  logic signed [ACC_W-1:0] pacc;
  logic signed [OPA_W-1:0] t_r;
  logic signed [OPA_W-1:0] g_r;
  logic signed [Q_W-1:0]   pred;
  logic signed [Q_W-1:0]   err;
  logic signed [Q_W-1:0]   out_pred;
  logic signed [Q_W-1:0]   out_err;
  logic signed [OPA_W-1:0] mac_a;
  logic signed [OPB_W-1:0] mac_b;
  logic                    mac_clr;
  logic signed [ACC_W-1:0] mac_acc;
  logic signed [RQ_W-1:0]  mac_rq;
  logic                    mac_busy;
  logic                    mac_done;
  logic signed [48:0]      wo_diff;
  logic signed [48:0]      lim49;
  logic signed [Q_W-1:0]   wo_new;

  // load decode
  logic [31:0]           idx32;
  logic                  sel_ok;
  logic [UW-1:0]         sel_unit;
  cell_wr_t              wr_bus;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bias_level    <= 24'sd65536;
      rate_hidden   <= 23'd32768;
      rate_output   <= 23'd3277;
      weight_limit  <= 23'd327680;
      hidden_in_use <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIAS_LEVEL:    bias_level    <= cfg_data;
        REG_RATE_HIDDEN:   rate_hidden   <= cfg_data[22:0];
        REG_RATE_OUTPUT:   rate_output   <= cfg_data[22:0];
        REG_WEIGHT_LIMIT:  weight_limit  <= cfg_data[22:0];
        REG_HIDDEN_IN_USE: hidden_in_use <= cfg_data[3:0];
        default:           bias_level    <= bias_level;
      endcase
    end
  end

  // active unit count and position in the pass
  always_comb begin
    if (32'(hidden_in_use) >= 32'(HIDDEN_UNITS)) begin
      n_act = CW'(HIDDEN_UNITS);
    end else begin
      n_act = CW'(hidden_in_use);
    end
    active    = (CW'(ucnt) < n_act);
    ucnt_last = (ucnt == UW'(HIDDEN_UNITS - 1));
    accept    = s_tvalid && s_tready;
  end

  // steps per unit in each pass
  always_comb begin
    case (pass)
      PASS_FWD: last_op = 3'd3;
      PASS_HID: last_op = 3'd6;
      default:  last_op = 3'd0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = (s_tuser == MODE_LOAD) ? ST_LOADW : ST_FETCH;
      ST_LOADW: state_next = ST_DONE;
      ST_FETCH: state_next = active ? ST_ISSUE : ST_SHIFT;
      ST_ISSUE: state_next = ST_WAIT;
      ST_WAIT:  if (mac_done) state_next = ST_POST;
      ST_POST: begin
        if (op != last_op) begin
          state_next = ST_ISSUE;
        end else if (pass == PASS_RATE) begin
          state_next = ST_FETCH;
        end else begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (!ucnt_last) begin
          state_next = ST_FETCH;
        end else if (pass == PASS_FWD) begin
          state_next = ST_PRED;
        end else if (pass == PASS_OUT) begin
          state_next = ST_FETCH;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_PRED:  state_next = ST_ERR;
      ST_ERR:   state_next = (mode_r == MODE_TRAIN) ? ST_ISSUE : ST_DONE;
      ST_DONE:  if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready   = (state == ST_IDLE);
    mac_start  = (state == ST_ISSUE);
    ring_shift = (state == ST_SHIFT);
    load_we    = (state == ST_LOADW);
    out_load   = (state == ST_DONE) && (!m_tvalid || m_tready);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pass     <= PASS_FWD;
      op       <= '0;
      ucnt     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            pass <= PASS_FWD;
            ucnt <= '0;
          end
        end
        ST_FETCH: op <= '0;
        ST_POST: begin
          if (op != last_op) begin
            op <= op + 3'd1;
          end else if (pass == PASS_RATE) begin
            pass <= PASS_OUT;
          end
        end
        ST_SHIFT: begin
          if (ucnt_last) begin
            ucnt <= '0;
            if (pass == PASS_OUT) pass <= PASS_HID;
          end else begin
            ucnt <= ucnt + UW'(1);
          end
        end
        ST_ERR: begin
          pass <= PASS_RATE;
          op   <= '0;
        end
        default: op <= op;
      endcase
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // mac operand select
  always_comb begin
    mac_a   = OPA_W'(x_a);
    mac_b   = work.w0;
    mac_clr = 1'b1;
    case (pass)
      PASS_FWD: begin
        case (op)
          3'd0: begin mac_a = OPA_W'(x_a); mac_b = work.w0; end
          3'd1: begin mac_a = OPA_W'(x_b); mac_b = work.w1; mac_clr = 1'b0; end
          3'd2: begin mac_a = OPA_W'(bias_level); mac_b = work.w2; mac_clr = 1'b0; end
          default: begin mac_a = OPA_W'(work.h); mac_b = work.wo; end
        endcase
      end
      PASS_RATE: begin
        mac_a = OPA_W'($signed({1'b0, rate_output}));
        mac_b = err;
      end
      PASS_OUT: begin
        mac_a = t_r;
        mac_b = OPB_W'(work.h);
      end
      default: begin
        case (op)
          3'd0: begin mac_a = OPA_W'(work.h); mac_b = OPB_W'(work.h); end
          3'd1: begin mac_a = g_r; mac_b = work.wo; end
          3'd2: begin mac_a = g_r; mac_b = err; end
          3'd3: begin mac_a = g_r; mac_b = $signed({1'b0, rate_hidden}); end
          3'd4: begin mac_a = g_r; mac_b = x_a; end
          3'd5: begin mac_a = g_r; mac_b = x_b; end
          default: begin mac_a = g_r; mac_b = bias_level; end
        endcase
      end
    endcase
  end

  // output weight step with clamp
  always_comb begin
    wo_diff = sub_w(work.wo, mac_rq);
    lim49   = $signed({26'b0, weight_limit});
    if (wo_diff > lim49) begin
      wo_new = $signed({1'b0, weight_limit});
    end else if (wo_diff < -lim49) begin
      wo_new = -$signed({1'b0, weight_limit});
    end else begin
      wo_new = wo_diff[Q_W-1:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          mode_r <= s_tuser;
          x_a    <= s_tdata[23:0];
          x_b    <= s_tdata[47:24];
          tgt    <= s_tdata[71:48];
          widx   <= s_tdata[76:72];
          wval   <= s_tdata[100:77];
          pacc   <= '0;
        end
      end
      ST_LOADW: begin
        pred <= '0;
        err  <= '0;
      end
      ST_FETCH: work <= ring[0];
      ST_POST: begin
        case (pass)
          PASS_FWD: begin
            if (op == 3'd2) work.h <= tanh_q(mac_rq);
            if (op == 3'd3) pacc <= pacc + mac_acc;
          end
          PASS_RATE: t_r <= mac_rq[OPA_W-1:0];
          PASS_OUT:  work.wo <= wo_new;
          default: begin
            case (op)
              3'd0: g_r <= 40'sd65536 - mac_rq[OPA_W-1:0];
              3'd4: work.w0 <= sat24(sub_w(work.w0, mac_rq));
              3'd5: work.w1 <= sat24(sub_w(work.w1, mac_rq));
              3'd6: work.w2 <= sat24(sub_w(work.w2, mac_rq));
              default: g_r <= mac_rq[OPA_W-1:0];
            endcase
          end
        endcase
      end
      ST_PRED: pred <= sat24(49'(rnd16(pacc)));
      ST_ERR:  err <= sat24(49'(25'(pred) - 25'(tgt)));
      ST_DONE: begin
        if (out_load) begin
          out_pred <= pred;
          out_err  <= err;
        end
      end
      default: pacc <= pacc;
    endcase
  end

  assign m_tdata = {out_err, out_pred};

  // weight load address decode
  always_comb begin
    idx32         = 32'(widx);
    sel_ok        = 1'b1;
    sel_unit      = '0;
    wr_bus.field  = FIELD_W0;
    wr_bus.value  = wval;
    if (idx32 < 32'(HIDDEN_UNITS)) begin
      sel_unit = UW'(idx32);
    end else if (idx32 < 32'(2 * HIDDEN_UNITS)) begin
      wr_bus.field = FIELD_W1;
      sel_unit     = UW'(idx32 - 32'(HIDDEN_UNITS));
    end else if (idx32 < 32'(3 * HIDDEN_UNITS)) begin
      wr_bus.field = FIELD_W2;
      sel_unit     = UW'(idx32 - 32'(2 * HIDDEN_UNITS));
    end else if (idx32 < 32'(4 * HIDDEN_UNITS)) begin
      wr_bus.field = FIELD_WO;
      sel_unit     = UW'(idx32 - 32'(3 * HIDDEN_UNITS));
    end else begin
      sel_ok = 1'b0;
    end
  end

  // ring of unit cells; the tail takes the worked unit back
  for (genvar j = 0; j < HIDDEN_UNITS; j++) begin : g_cell
    cell_t d_in;
    if (j == HIDDEN_UNITS - 1) begin : g_tail
      assign d_in = work;
    end else begin : g_link
      assign d_in = ring[j + 1];
    end
    mbt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ring_shift),
      .d     (d_in),
      .wr_en (load_we && sel_ok && (sel_unit == UW'(j))),
      .wr    (wr_bus),
      .q     (ring[j])
    );
  end

  mbt_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_start),
    .clr   (mac_clr),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (mac_acc),
    .rq    (mac_rq),
    .busy  (mac_busy),
    .done  (mac_done)
  );

  `ASSERT_NEVER(a_done_outside_wait, clk, rst, mac_done && (state != ST_WAIT), "mac result lost")
  `ASSERT_NEVER(a_shift_while_busy, clk, rst, ring_shift && mac_busy, "ring moved under mac")
  `ASSERT_AT(a_ucnt_range, clk, rst, ucnt <= UW'(HIDDEN_UNITS - 1), "unit count out of range")

endmodule
